// ----- design/tebp_pkg.sv -----
// Shared types, phase codes, status codes and field tables for the trim element bit parser.
package tebp_pkg;

    typedef logic [4:0] t_phase;
    typedef logic [2:0] t_status;

    // Parse phases; each names the field that is being collected.
    localparam t_phase PH_WARP    = 5'd0;
    localparam t_phase PH_RSV     = 5'd1;
    localparam t_phase PH_GLOB    = 5'd2;
    localparam t_phase PH_DEF     = 5'd3;
    localparam t_phase PH_DIS     = 5'd4;
    localparam t_phase PH_PRES    = 5'd5;
    localparam t_phase PH_CEN     = 5'd6;
    localparam t_phase PH_SUR     = 5'd7;
    localparam t_phase PH_HGT     = 5'd8;
    localparam t_phase PH_TBS     = 5'd9;
    localparam t_phase PH_TBA     = 5'd10;
    localparam t_phase PH_LIS     = 5'd11;
    localparam t_phase PH_LIA     = 5'd12;
    localparam t_phase PH_POF     = 5'd13;
    localparam t_phase PH_OBJ     = 5'd14;
    localparam t_phase PH_PAD     = 5'd15;
    localparam t_phase PH_END_CFG = 5'd16;

    // Final parse status codes.
    localparam t_status ST_PASS      = 3'd0;
    localparam t_status ST_SHAPE     = 3'd1;
    localparam t_status ST_TRUNC     = 3'd2;
    localparam t_status ST_WARP      = 3'd3;
    localparam t_status ST_RESERVED  = 3'd4;
    localparam t_status ST_GLOBAL    = 3'd5;
    localparam t_status ST_LEVEL     = 3'd6;
    localparam t_status ST_PADDING   = 3'd7;

    // Global mode that carries trim configurations, and the invalid one.
    localparam logic [1:0] GLOBAL_TRIM    = 2'd2;
    localparam logic [1:0] GLOBAL_INVALID = 2'd3;
    // Surround and height codes below this are not legal levels.
    localparam logic [4:0] LEVEL_MIN = 5'd4;

    // Number of bits in the field collected in a given phase.
    function automatic logic [2:0] field_len(input t_phase phase);
        logic [2:0] len;
        unique case (phase)
            PH_WARP, PH_RSV, PH_GLOB:                 len = 3'd2;
            PH_PRES:                                  len = 3'd5;
            PH_CEN, PH_SUR, PH_HGT, PH_TBA, PH_LIA:   len = 3'd4;
            default:                                  len = 3'd1;
        endcase
        return len;
    endfunction

    // First present balance field at or after phase 'from', else end of configuration.
    // Mask bit 4 is centre, then surround, height, top/bottom and listener balance.
    function automatic t_phase next_balance(input logic [4:0] mask, input t_phase from);
        t_phase nxt;
        priority if (mask[4] && PH_CEN >= from) begin
            nxt = PH_CEN;
        end else if (mask[3] && PH_SUR >= from) begin
            nxt = PH_SUR;
        end else if (mask[2] && PH_HGT >= from) begin
            nxt = PH_HGT;
        end else if (mask[1] && PH_TBS >= from) begin
            nxt = PH_TBS;
        end else if (mask[0] && PH_LIS >= from) begin
            nxt = PH_LIS;
        end else begin
            nxt = PH_END_CFG;
        end
        return nxt;
    endfunction

endpackage

// ----- design/trim_element_bit_parser_unit.sv -----
// Top level of the bit-serial trim metadata element parser.
//
// The parser takes a trim metadata element one body bit per input transaction, most
// significant bit first, with s_axis_tlast on the final bit of the body. It decodes the
// 6-bit header (warp, reserved, global mode) and, in global mode 2, the trim
// configurations with their default and disable flags, presence mask and optional
// centre, surround, height and balance fields, then the per-object disable list and the
// zero padding. Every field is reported by one output transaction on the bit that
// completes it; the transaction that ends the parse carries m_axis_tlast high and the
// final status (pass, shape, truncated, warp, reserved bits, global mode, level code or
// padding). Bits that complete no field and do not end the parse produce no output.
// After an early end, the remaining bits up to the next tlast are dropped. The block
// takes one bit per clock cycle: an input register and a result register bracket a
// single step of the field counters and phase logic, so throughput is set by nothing
// but the output side's tready. A bit's result is presented on m_axis_tvalid from the
// result register, which is loaded as the bit leaves the input register. The
// object_count register is written over the cfg channel (always ready) and must only
// change while the parser is idle; it resets to 1.
module trim_element_bit_parser_unit
    import tebp_pkg::*;
#(
    parameter int TRIM_CONFIGS = 9,
    parameter int MAX_OBJECTS  = 159
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // Input bit stream.
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // [0] bit_value, [7:1] zero
    input  logic        s_axis_tlast,   // is_last
    // Decoded field stream.
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [23:0] m_axis_tdata,   // [0] field_valid, [4:1] config_index,
                                        // [12:5] object_index, [17:13] field_value,
                                        // [20:18] status, [23:21] zero
    output logic [3:0]  m_axis_tuser,   // field_kind
    output logic        m_axis_tlast,   // done_res
    // object_count register write.
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [7:0]  i_cfg_data
);

    localparam logic [4:0] CFG_LIMIT = 5'(TRIM_CONFIGS);
    localparam logic [7:0] OBJ_LIMIT = 8'(MAX_OBJECTS);

    // Configuration.
    logic [7:0] r_obj_count;

    // Input register.
    logic       r_in_valid;
    logic       r_in_bit;
    logic       r_in_last;

    // Parse state.
    t_phase     r_phase,     n_phase;
    logic [2:0] r_bit_cnt,   n_bit_cnt;
    logic [4:0] r_shift,     n_shift;
    logic [3:0] r_cfg_cnt,   n_cfg_cnt;
    logic [7:0] r_obj_cnt,   n_obj_cnt;
    logic [4:0] r_pres_mask, n_pres_mask;
    logic       r_level_bad, n_level_bad;
    logic [3:0] r_hdr,       n_hdr;       // warp in [3:2], reserved in [1:0]
    logic       r_finished,  n_finished;

    // Result register.
    logic       r_out_valid;
    logic       r_o_emit;
    logic [3:0] r_o_kind;
    logic [3:0] r_o_cfg;
    logic [7:0] r_o_obj;
    logic [4:0] r_o_val;
    logic       r_o_done;
    t_status    r_o_status;

    // Step results.
    logic       w_adv;
    logic       w_res;
    logic       w_emit;
    logic [3:0] w_kind;
    logic [3:0] w_cfg;
    logic [7:0] w_obj;
    logic [4:0] w_val;
    logic       w_done;
    t_status    w_status;

    // The bit in the input register is processed when the result register can take it.
    assign w_adv         = r_in_valid && (!r_out_valid || m_axis_tready);
    assign s_axis_tready = !r_in_valid || w_adv;
    assign o_cfg_ready   = 1'b1;

    // One parse step for the registered bit.
    always_comb begin
        logic [4:0] acc;
        logic [3:0] cnt;
        logic [3:0] cfg_inc;
        logic [7:0] obj_inc;
        t_phase     nxt;
        logic       go_next_cfg;

        n_phase     = r_phase;
        n_bit_cnt   = r_bit_cnt;
        n_shift     = r_shift;
        n_cfg_cnt   = r_cfg_cnt;
        n_obj_cnt   = r_obj_cnt;
        n_pres_mask = r_pres_mask;
        n_level_bad = r_level_bad;
        n_hdr       = r_hdr;
        n_finished  = r_finished;

        w_emit   = 1'b0;
        w_kind   = 4'd0;
        w_cfg    = 4'd0;
        w_obj    = 8'd0;
        w_val    = 5'd0;
        w_done   = 1'b0;
        w_status = ST_PASS;

        acc         = {r_shift[3:0], r_in_bit};
        cnt         = {1'b0, r_bit_cnt} + 4'd1;
        cfg_inc     = r_cfg_cnt + 4'd1;
        obj_inc     = r_obj_cnt + 8'd1;
        nxt         = PH_PAD;
        go_next_cfg = 1'b0;

        if (r_finished) begin
            // Dropping the rest of an element that ended early.
            if (r_in_last) begin
                n_finished = 1'b0;
            end
        end else if (r_phase == PH_WARP && r_bit_cnt == 3'd0
                     && (r_obj_count == 8'd0 || r_obj_count > OBJ_LIMIT)) begin
            w_done   = 1'b1;
            w_status = ST_SHAPE;
        end else if (r_phase == PH_PAD) begin
            if (r_in_bit) begin
                w_done   = 1'b1;
                w_status = ST_PADDING;
            end else if (r_in_last) begin
                w_done   = 1'b1;
                w_status = ST_PASS;
            end
        end else begin
            if (cnt < {1'b0, field_len(r_phase)}) begin
                n_shift   = acc;
                n_bit_cnt = cnt[2:0];
            end else begin
                w_emit    = 1'b1;
                w_kind    = r_phase[3:0];
                w_val     = acc;
                n_shift   = 5'd0;
                n_bit_cnt = 3'd0;
                if (r_phase >= PH_DEF && r_phase <= PH_LIA) begin
                    w_cfg = r_cfg_cnt;
                end
                if (r_phase == PH_OBJ) begin
                    w_obj = r_obj_cnt;
                end

                unique case (r_phase)
                    PH_WARP: begin
                        n_hdr[3:2] = acc[1:0];
                        nxt        = PH_RSV;
                    end
                    PH_RSV: begin
                        n_hdr[1:0] = acc[1:0];
                        nxt        = PH_GLOB;
                    end
                    PH_GLOB: begin
                        // Header checks in priority order once all six bits are in.
                        if (r_hdr[3]) begin
                            w_status = ST_WARP;
                        end else if (r_hdr[1:0] != 2'd0) begin
                            w_status = ST_RESERVED;
                        end else if (acc[1:0] == GLOBAL_INVALID) begin
                            w_status = ST_GLOBAL;
                        end else if (acc[1:0] == GLOBAL_TRIM) begin
                            n_cfg_cnt = 4'd0;
                            nxt       = PH_DEF;
                        end else begin
                            nxt = PH_POF;
                        end
                    end
                    PH_DEF, PH_DIS: begin
                        // A set default or disable flag skips the rest of the configuration.
                        if (acc[0]) begin
                            go_next_cfg = 1'b1;
                        end else begin
                            nxt = (r_phase == PH_DEF) ? PH_DIS : PH_PRES;
                        end
                    end
                    PH_PRES: begin
                        n_pres_mask = acc;
                        n_level_bad = 1'b0;
                        nxt         = next_balance(acc, PH_CEN);
                    end
                    PH_CEN: nxt = next_balance(r_pres_mask, PH_SUR);
                    PH_SUR: begin
                        if (acc < LEVEL_MIN) begin
                            n_level_bad = 1'b1;
                        end
                        nxt = next_balance(r_pres_mask, PH_HGT);
                    end
                    PH_HGT: begin
                        if (acc < LEVEL_MIN) begin
                            n_level_bad = 1'b1;
                        end
                        nxt = next_balance(r_pres_mask, PH_TBS);
                    end
                    PH_TBS: nxt = PH_TBA;
                    PH_TBA: nxt = next_balance(r_pres_mask, PH_LIS);
                    PH_LIS: nxt = PH_LIA;
                    PH_LIA: nxt = PH_END_CFG;
                    PH_POF: begin
                        n_obj_cnt = 8'd0;
                        nxt       = acc[0] ? PH_OBJ : PH_PAD;
                    end
                    PH_OBJ: begin
                        n_obj_cnt = obj_inc;
                        nxt = (obj_inc >= r_obj_count || obj_inc == 8'd0) ? PH_PAD : PH_OBJ;
                    end
                    default: nxt = PH_PAD;
                endcase

                if (w_status == ST_PASS) begin
                    if (nxt == PH_END_CFG) begin
                        if (n_level_bad) begin
                            w_status = ST_LEVEL;
                        end else begin
                            go_next_cfg = 1'b1;
                        end
                    end else if (!go_next_cfg) begin
                        n_phase = nxt;
                    end
                    if (go_next_cfg) begin
                        n_cfg_cnt = cfg_inc;
                        n_phase   = ({1'b0, cfg_inc} >= CFG_LIMIT || cfg_inc == 4'd0)
                                    ? PH_POF : PH_DEF;
                    end
                end
                if (w_status != ST_PASS) begin
                    w_done = 1'b1;
                end
            end

            // End of body: pass if only padding is left, else the field list is truncated.
            if (!w_done && r_in_last) begin
                w_done   = 1'b1;
                w_status = (n_phase == PH_PAD) ? ST_PASS : ST_TRUNC;
            end
        end

        if (w_done) begin
            n_phase     = PH_WARP;
            n_bit_cnt   = 3'd0;
            n_shift     = 5'd0;
            n_cfg_cnt   = 4'd0;
            n_obj_cnt   = 8'd0;
            n_pres_mask = 5'd0;
            n_level_bad = 1'b0;
            n_hdr       = 4'd0;
            n_finished  = !r_in_last;
        end

        w_res = w_emit || w_done;
    end

    // Control and parse state.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_obj_count <= 8'd1;
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
            r_phase     <= PH_WARP;
            r_bit_cnt   <= 3'd0;
            r_shift     <= 5'd0;
            r_cfg_cnt   <= 4'd0;
            r_obj_cnt   <= 8'd0;
            r_pres_mask <= 5'd0;
            r_level_bad <= 1'b0;
            r_hdr       <= 4'd0;
            r_finished  <= 1'b0;
        end else begin
            if (i_cfg_valid) begin
                r_obj_count <= i_cfg_data;
            end

            if (s_axis_tvalid && s_axis_tready) begin
                r_in_valid <= 1'b1;
            end else if (w_adv) begin
                r_in_valid <= 1'b0;
            end

            if (w_adv) begin
                r_out_valid <= w_res;
                r_phase     <= n_phase;
                r_bit_cnt   <= n_bit_cnt;
                r_shift     <= n_shift;
                r_cfg_cnt   <= n_cfg_cnt;
                r_obj_cnt   <= n_obj_cnt;
                r_pres_mask <= n_pres_mask;
                r_level_bad <= n_level_bad;
                r_hdr       <= n_hdr;
                r_finished  <= n_finished;
            end else if (m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Payload registers.
    always_ff @(posedge i_clk) begin
        if (s_axis_tvalid && s_axis_tready) begin
            r_in_bit  <= s_axis_tdata[0];
            r_in_last <= s_axis_tlast;
        end
        if (w_adv && w_res) begin
            r_o_emit   <= w_emit;
            r_o_kind   <= w_kind;
            r_o_cfg    <= w_cfg;
            r_o_obj    <= w_obj;
            r_o_val    <= w_val;
            r_o_done   <= w_done;
            r_o_status <= w_status;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {3'd0, r_o_status, r_o_val, r_o_obj, r_o_cfg, r_o_emit};
    assign m_axis_tuser  = r_o_kind;
    assign m_axis_tlast  = r_o_done;

endmodule
